>>> src/assert_macros.svh
// Assertion macros used by the checker in sbsc_check.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SBSC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication.
`define SBSC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> src/sbsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sbsc_pkg;
	localparam int CW       = 24;          // coordinate width, Q16.8
	localparam int FW       = 16;          // fraction bits
	localparam int DW       = CW + 1;      // delta and offset width
	localparam int RW       = CW + 3;      // divider remainder width
	localparam int QW       = FW + 2;      // quotient bits, top one flags overflow
	localparam int LW       = FW + 1;      // interval bound width
	localparam int TW       = FW + 3;      // signed slab parameter width
	localparam int PW       = DW + LW + 1; // entry product width
	localparam int NCELL    = QW;
	localparam int NLANE    = 4;
	localparam int FRAC_ONE = 1 << FW;

	localparam int L_XLO = 0;
	localparam int L_XHI = 1;
	localparam int L_YLO = 2;
	localparam int L_YHI = 3;

	// one divider lane: offset over delta
	typedef struct packed {
		logic [RW-1:0] r;
		logic [RW-1:0] dv;
		logic [QW-1:0] q;
		logic          neg;
	} lane_t;

	typedef lane_t [NLANE-1:0] lanes_t;

	// data carried alongside the dividers
	typedef struct packed {
		logic signed [CW-1:0] sx;
		logic signed [CW-1:0] sy;
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
		logic                 zx;
		logic                 zy;
		logic                 rx;
		logic                 ry;
	} side_t;
endpackage
`default_nettype wire

>>> src/sbsc_prep.sv
`timescale 1ns / 1ps
`default_nettype none
module sbsc_prep (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic                           in_valid,
	input  wire logic signed [sbsc_pkg::CW-1:0] start_x,
	input  wire logic signed [sbsc_pkg::CW-1:0] start_y,
	input  wire logic signed [sbsc_pkg::CW-1:0] end_x,
	input  wire logic signed [sbsc_pkg::CW-1:0] end_y,
	input  wire logic signed [sbsc_pkg::CW-1:0] box_left,
	input  wire logic signed [sbsc_pkg::CW-1:0] box_top,
	input  wire logic signed [sbsc_pkg::CW-1:0] box_right,
	input  wire logic signed [sbsc_pkg::CW-1:0] box_bottom,
	output logic                                valid_out,
	output sbsc_pkg::side_t                     side_out,
	output sbsc_pkg::lanes_t                    lanes_out
);
	localparam int DW = sbsc_pkg::DW;
	localparam int RW = sbsc_pkg::RW;

	logic                        v_s1;
	logic signed [sbsc_pkg::CW-1:0] sx_s1, sy_s1;
	logic signed [DW-1:0]        dx_s1, dy_s1, nxl_s1, nxh_s1, nyl_s1, nyh_s1;

	function automatic sbsc_pkg::lane_t mk_lane(input logic signed [DW-1:0] n,
			input logic nd, input logic [DW-1:0] dabs);
		logic signed [DW-1:0] m;
		sbsc_pkg::lane_t      l;
		m     = nd ? -n : n;
		l.neg = m[DW-1];
		l.r   = l.neg ? '0 : {{(RW-DW){1'b0}}, m};
		l.dv  = {{(RW-DW-1){1'b0}}, dabs, 1'b0};
		l.q   = '0;
		return l;
	endfunction

	function automatic logic in_slab(input logic signed [DW-1:0] a,
			input logic signed [DW-1:0] b);
		return (a <= 0 && b >= 0) || (b <= 0 && a >= 0);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1  <= start_x;
			sy_s1  <= start_y;
			dx_s1  <= DW'(end_x) - DW'(start_x);
			dy_s1  <= DW'(end_y) - DW'(start_y);
			nxl_s1 <= DW'(box_left) - DW'(start_x);
			nxh_s1 <= DW'(box_right) - DW'(start_x);
			nyl_s1 <= DW'(box_top) - DW'(start_y);
			nyh_s1 <= DW'(box_bottom) - DW'(start_y);
		end
	end

	logic          negx, negy;
	logic [DW-1:0] ax, ay;

	always_comb begin
		negx = dx_s1[DW-1];
		negy = dy_s1[DW-1];
		ax   = negx ? DW'(-dx_s1) : DW'(dx_s1);
		ay   = negy ? DW'(-dy_s1) : DW'(dy_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_out.sx <= sx_s1;
			side_out.sy <= sy_s1;
			side_out.dx <= dx_s1;
			side_out.dy <= dy_s1;
			side_out.zx <= (dx_s1 == '0);
			side_out.zy <= (dy_s1 == '0);
			side_out.rx <= in_slab(nxl_s1, nxh_s1);
			side_out.ry <= in_slab(nyl_s1, nyh_s1);
			lanes_out[sbsc_pkg::L_XLO] <= mk_lane(nxl_s1, negx, ax);
			lanes_out[sbsc_pkg::L_XHI] <= mk_lane(nxh_s1, negx, ax);
			lanes_out[sbsc_pkg::L_YLO] <= mk_lane(nyl_s1, negy, ay);
			lanes_out[sbsc_pkg::L_YHI] <= mk_lane(nyh_s1, negy, ay);
		end
	end
endmodule
`default_nettype wire

>>> src/sbsc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One quotient bit for each of the four lanes.
module sbsc_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              valid_in,
	input  sbsc_pkg::side_t        side_in,
	input  sbsc_pkg::lanes_t       lanes_in,
	output logic                   valid_out,
	output sbsc_pkg::side_t        side_out,
	output sbsc_pkg::lanes_t       lanes_out
);
	sbsc_pkg::lanes_t nxt;

	always_comb begin
		for (int i = 0; i < sbsc_pkg::NLANE; i++) begin
			logic                   ge;
			logic [sbsc_pkg::RW-1:0] diff;
			ge           = lanes_in[i].r >= lanes_in[i].dv;
			diff         = ge ? lanes_in[i].r - lanes_in[i].dv : lanes_in[i].r;
			nxt[i].r     = {diff[sbsc_pkg::RW-2:0], 1'b0};
			nxt[i].dv    = lanes_in[i].dv;
			nxt[i].q     = {lanes_in[i].q[sbsc_pkg::QW-2:0], ge};
			nxt[i].neg   = lanes_in[i].neg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_out  <= side_in;
			lanes_out <= nxt;
		end
	end
endmodule
`default_nettype wire

>>> src/sbsc_finish.sv
`timescale 1ns / 1ps
`default_nettype none
module sbsc_finish (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            en,
	input  wire logic                            valid_in,
	input  sbsc_pkg::side_t                      side_in,
	input  sbsc_pkg::lanes_t                     lanes_in,
	output logic                                 out_valid,
	output logic                                 hit,
	output logic [sbsc_pkg::LW-1:0]              entry_fraction,
	output logic signed [sbsc_pkg::CW-1:0]       entry_x,
	output logic signed [sbsc_pkg::CW-1:0]       entry_y
);
	localparam int TW = sbsc_pkg::TW;
	localparam int LW = sbsc_pkg::LW;
	localparam int PW = sbsc_pkg::PW;
	localparam int CW = sbsc_pkg::CW;
	localparam logic signed [TW-1:0] T_ONE = TW'(sbsc_pkg::FRAC_ONE);
	localparam logic signed [TW-1:0] T_MAX = TW'(sbsc_pkg::FRAC_ONE + 1);
	localparam logic signed [PW-1:0] HALF  = PW'(sbsc_pkg::FRAC_ONE / 2);

	// saturated slab parameter in [-1, one + 1]
	function automatic logic signed [TW-1:0] sat_t(input sbsc_pkg::lane_t l);
		logic [LW-1:0] v;
		v = l.q[sbsc_pkg::QW-2:0];
		if (l.neg) return '1;
		if (l.q[sbsc_pkg::QW-1] || $signed({2'b00, v}) > T_MAX) return T_MAX;
		return $signed({2'b00, v});
	endfunction

	logic                 ok;
	logic signed [TW-1:0] lo, hi, tl, th, tt;

	always_comb begin
		lo = '0;
		hi = T_ONE;
		// x slab
		tl = sat_t(lanes_in[sbsc_pkg::L_XLO]);
		th = sat_t(lanes_in[sbsc_pkg::L_XHI]);
		if (tl > th) begin
			tt = tl; tl = th; th = tt;
		end else begin
			tt = tl;
		end
		if (side_in.zx) begin
			ok = side_in.rx;
		end else if (th < lo || tl > hi) begin
			ok = 1'b0;
		end else begin
			if (tl > lo) lo = tl;
			if (th < hi) hi = th;
			ok = lo <= hi;
		end
		// y slab
		tl = sat_t(lanes_in[sbsc_pkg::L_YLO]);
		th = sat_t(lanes_in[sbsc_pkg::L_YHI]);
		if (tl > th) begin
			tt = tl; tl = th; th = tt;
		end
		if (ok) begin
			if (side_in.zy) begin
				ok = side_in.ry;
			end else if (th < lo || tl > hi) begin
				ok = 1'b0;
			end else begin
				if (tl > lo) lo = tl;
				if (th < hi) hi = th;
				ok = lo <= hi;
			end
		end
	end

	logic                 v_s1, v_s2, hit_s1, hit_s2;
	logic [LW-1:0]        low_s1, low_s2;
	logic signed [CW-1:0] sx_s1, sy_s1, sx_s2, sy_s2;
	logic signed [sbsc_pkg::DW-1:0] dx_s1, dy_s1;
	logic signed [PW-1:0] px_s2, py_s2, shx, shy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= valid_in;
			v_s2      <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_comb begin
		shx = px_s2 >>> sbsc_pkg::FW;
		shy = py_s2 >>> sbsc_pkg::FW;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s1 <= ok;
			low_s1 <= lo[LW-1:0];
			sx_s1  <= side_in.sx;
			sy_s1  <= side_in.sy;
			dx_s1  <= side_in.dx;
			dy_s1  <= side_in.dy;

			hit_s2 <= hit_s1;
			low_s2 <= low_s1;
			sx_s2  <= sx_s1;
			sy_s2  <= sy_s1;
			px_s2  <= PW'(dx_s1) * PW'($signed({1'b0, low_s1})) + HALF;
			py_s2  <= PW'(dy_s1) * PW'($signed({1'b0, low_s1})) + HALF;

			hit            <= hit_s2;
			entry_fraction <= hit_s2 ? low_s2 : '0;
			entry_x        <= hit_s2 ? sx_s2 + shx[CW-1:0] : '0;
			entry_y        <= hit_s2 ? sy_s2 + shy[CW-1:0] : '0;
		end
	end
endmodule
`default_nettype wire

>>> src/segment_box_slab_clip.sv
`timescale 1ns / 1ps
`default_nettype none
// Segment against axis-aligned box, slab clipping (Liang-Barsky).
// Input channel: in_valid / in_stall with the segment ends and box corners,
// signed Q16.8. Output channel: out_valid / out_stall with hit, entry
// fraction (unsigned Q1.16, 65536 is 1.0) and entry point; all zero on a miss.
// A transaction is taken on a rising edge with valid high and stall low.
// Throughput: one transaction per cycle while no waiting result is stalled. The
// pipeline is made of two setup stages, a chain of 18 divider cells (one
// quotient bit per cell for all four slab edges at once), a clip stage, a
// multiply stage and the output register.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall rises in the same cycle; nothing is dropped.
// Reset (arst_n low) clears every valid flag; no result is shown until a new
// transaction has gone through.
module segment_box_slab_clip (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic signed [sbsc_pkg::CW-1:0] start_x,
	input  wire logic signed [sbsc_pkg::CW-1:0] start_y,
	input  wire logic signed [sbsc_pkg::CW-1:0] end_x,
	input  wire logic signed [sbsc_pkg::CW-1:0] end_y,
	input  wire logic signed [sbsc_pkg::CW-1:0] box_left,
	input  wire logic signed [sbsc_pkg::CW-1:0] box_top,
	input  wire logic signed [sbsc_pkg::CW-1:0] box_right,
	input  wire logic signed [sbsc_pkg::CW-1:0] box_bottom,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                hit,
	output logic [sbsc_pkg::LW-1:0]             entry_fraction,
	output logic signed [sbsc_pkg::CW-1:0]      entry_x,
	output logic signed [sbsc_pkg::CW-1:0]      entry_y
);
	// global advance: everything moves unless a waiting result is held back
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	logic             vld   [sbsc_pkg::NCELL+1];
	sbsc_pkg::side_t  side  [sbsc_pkg::NCELL+1];
	sbsc_pkg::lanes_t lanes [sbsc_pkg::NCELL+1];

	sbsc_prep u_prep (
		.clk, .arst_n, .en, .in_valid,
		.start_x, .start_y, .end_x, .end_y,
		.box_left, .box_top, .box_right, .box_bottom,
		.valid_out (vld[0]),
		.side_out  (side[0]),
		.lanes_out (lanes[0])
	);

	// restoring division, most significant quotient bit first
	for (genvar g = 0; g < sbsc_pkg::NCELL; g++) begin : g_cell
		sbsc_cell u_cell (
			.clk, .arst_n, .en,
			.valid_in  (vld[g]),
			.side_in   (side[g]),
			.lanes_in  (lanes[g]),
			.valid_out (vld[g+1]),
			.side_out  (side[g+1]),
			.lanes_out (lanes[g+1])
		);
	end

	sbsc_finish u_finish (
		.clk, .arst_n, .en,
		.valid_in  (vld[sbsc_pkg::NCELL]),
		.side_in   (side[sbsc_pkg::NCELL]),
		.lanes_in  (lanes[sbsc_pkg::NCELL]),
		.out_valid, .hit, .entry_fraction, .entry_x, .entry_y
	);
endmodule
`default_nettype wire

>>> src/sbsc_check.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sbsc_check (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_stall,
	input wire logic                           out_valid,
	input wire logic                           out_stall,
	input wire logic                           hit,
	input wire logic [sbsc_pkg::LW-1:0]        entry_fraction,
	input wire logic signed [sbsc_pkg::CW-1:0] entry_x,
	input wire logic signed [sbsc_pkg::CW-1:0] entry_y
);
	`SBSC_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid)
	`SBSC_ASSERT_IMP(a_backpressure, out_valid && out_stall, in_stall)
	`SBSC_ASSERT_IMP(a_miss_zero, out_valid && !hit, entry_fraction == '0 && entry_x == '0 && entry_y == '0)
	`SBSC_ASSERT_IMP(a_frac_range, out_valid && hit, entry_fraction <= sbsc_pkg::LW'(sbsc_pkg::FRAC_ONE))
endmodule

bind segment_box_slab_clip sbsc_check u_sbsc_check (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.hit            (hit),
	.entry_fraction (entry_fraction),
	.entry_x        (entry_x),
	.entry_y        (entry_y)
);
`default_nettype wire
